/* hw/rtl/char_grid_autocrop_defines.svh */
// ----------------------------------------------------------------------------
// char_grid_autocrop assertion macros
// shared concurrent assertion forms, clocked on clk_i with reset rst_ni
// ----------------------------------------------------------------------------
`ifndef CHAR_GRID_AUTOCROP_DEFINES_SVH
`define CHAR_GRID_AUTOCROP_DEFINES_SVH

// same-cycle implication
`define CGAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CGAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/cgac_pkg.sv */
// ----------------------------------------------------------------------------
// cgac_pkg
// types and constants of the character grid with bounding-box auto-crop
// ----------------------------------------------------------------------------
package cgac_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TRIM  = 2'd2;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_BLANK = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_GRID_ROWS  = 2'd0;
  localparam logic [1:0] REG_GRID_COLS  = 2'd1;
  localparam logic [1:0] REG_BLANK_CHAR = 2'd2;
  localparam logic [1:0] REG_BLANK_ATTR = 2'd3;

  // register reset values
  localparam logic [6:0] GRID_ROWS_RST  = 7'd64;
  localparam logic [6:0] GRID_COLS_RST  = 7'd64;
  localparam logic [7:0] BLANK_CHAR_RST = 8'd32;
  localparam logic [7:0] BLANK_ATTR_RST = 8'd0;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] char_in;
    logic [7:0] attr_in;
    logic       shrink;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] char_out;
    logic [7:0] attr_out;
    logic [5:0] box_top;
    logic [5:0] box_left;
    logic [6:0] box_rows;
    logic [6:0] box_cols;
  } out_t;

endpackage

/* hw/rtl/char_grid_autocrop.sv */
// ----------------------------------------------------------------------------
// char_grid_autocrop
// character grid with cell write/read and bounding-box trim to the origin
// ----------------------------------------------------------------------------
// Two MAX_ROWS x MAX_COLS planes (character, attribute) sit in synchronous
// memories sharing one read port and one write port. A trim has a start
// step, then reads every cell of the active area once, one per cycle, then
// has a drain and a decision step; if the box is not already at the origin
// it then moves it cell by cell (read source, write destination, blank
// source), and finishes with an end step. The single memory read port
// sets the scan length. Cells hold nothing defined until written; there is
// no clearing pass after reset. A result waits in the output register while
// the next item is taken in.
// ----------------------------------------------------------------------------
`include "char_grid_autocrop_defines.svh"

module char_grid_autocrop #(
  parameter int MAX_ROWS = cgac_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = cgac_pkg::MAX_COLS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cgac_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cgac_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [7:0]     cfg_data_i
);

  localparam int CELLS   = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int ROW_LIM = (MAX_ROWS < 127) ? MAX_ROWS : 127;
  localparam int COL_LIM = (MAX_COLS < 127) ? MAX_COLS : 127;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD     = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DRAIN  = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_MV_RD  = 4'd5;
  localparam logic [3:0] S_MV_WD  = 4'd6;
  localparam logic [3:0] S_MV_WS  = 4'd7;
  localparam logic [3:0] S_TEND   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [6:0] r, input logic [6:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

  // registers
  logic [6:0] grid_rows_q, grid_rows_d, grid_cols_q, grid_cols_d;
  logic [7:0] blank_char_q, blank_char_d, blank_attr_q, blank_attr_d;
  logic       shrunk_q, shrunk_d;
  logic [6:0] act_rows_q, act_rows_d, act_cols_q, act_cols_d;
  logic [3:0] state_q, state_d;
  logic [6:0] sr_q, sr_d, sc_q, sc_d;
  logic       sv_q, sv_d;
  logic [6:0] pr_q, pr_d, pc_q, pc_d;
  logic       found_q, found_d;
  logic [6:0] top_q, top_d, left_q, left_d, bot_q, bot_d, right_q, right_d;
  logic [6:0] mi_q, mi_d, mj_q, mj_d;
  logic       shrink_q, shrink_d;
  cgac_pkg::out_t res_q, res_d, out_q, out_d;
  logic       out_valid_q, out_valid_d;

  // memory
  logic [7:0]        char_mem [CELLS];
  logic [7:0]        attr_mem [CELLS];
  logic [7:0]        char_rd_q, attr_rd_q;
  logic              mem_we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wchar, wattr;

  // combinational
  logic [6:0]     raw_rows, raw_cols, area_rows, area_cols, bh, bw;
  logic           in_acc, out_free, fin, in_range;
  cgac_pkg::out_t res;

  always_comb begin
    raw_rows  = shrunk_q ? act_rows_q : grid_rows_q;
    raw_cols  = shrunk_q ? act_cols_q : grid_cols_q;
    area_rows = (raw_rows > 7'(ROW_LIM)) ? 7'(ROW_LIM) : raw_rows;
    area_cols = (raw_cols > 7'(COL_LIM)) ? 7'(COL_LIM) : raw_cols;
    bh        = bot_q - top_q + 7'd1;
    bw        = right_q - left_q + 7'd1;
    in_acc    = in_valid_i && (state_q == S_IDLE);
    out_free  = !out_valid_q || out_ready_i;
    in_range  = ({1'b0, in_data_i.row} < area_rows) && ({1'b0, in_data_i.col} < area_cols);
  end

  always_comb begin
    grid_rows_d  = grid_rows_q;
    grid_cols_d  = grid_cols_q;
    blank_char_d = blank_char_q;
    blank_attr_d = blank_attr_q;
    shrunk_d     = shrunk_q;
    act_rows_d   = act_rows_q;
    act_cols_d   = act_cols_q;
    state_d      = state_q;
    sr_d         = sr_q;
    sc_d         = sc_q;
    sv_d         = 1'b0;
    pr_d         = sr_q;
    pc_d         = sc_q;
    found_d      = found_q;
    top_d        = top_q;
    left_d       = left_q;
    bot_d        = bot_q;
    right_d      = right_q;
    mi_d         = mi_q;
    mj_d         = mj_q;
    shrink_d     = shrink_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    fin          = 1'b0;
    res          = '0;
    mem_we       = 1'b0;
    waddr        = cell_addr({1'b0, in_data_i.row}, {1'b0, in_data_i.col});
    wchar        = in_data_i.char_in;
    wattr        = in_data_i.attr_in;
    raddr        = cell_addr({1'b0, in_data_i.row}, {1'b0, in_data_i.col});

    // bounding box update from the cell read in the previous cycle
    if (sv_q && (char_rd_q != blank_char_q)) begin
      if (!found_q) begin
        found_d = 1'b1;
        top_d   = pr_q;
        left_d  = pc_q;
        bot_d   = pr_q;
        right_d = pc_q;
      end else begin
        if (pc_q < left_q) left_d = pc_q;
        bot_d = pr_q;
        if (pc_q > right_q) right_d = pc_q;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          shrink_d = in_data_i.shrink;
          unique case (in_data_i.cmd)
            cgac_pkg::CMD_WRITE: begin
              fin = 1'b1;
              if (in_range) mem_we = 1'b1;
              else res.status = cgac_pkg::ST_RANGE;
            end
            cgac_pkg::CMD_READ: begin
              if (in_range) begin
                state_d = S_RD;
              end else begin
                fin        = 1'b1;
                res.status = cgac_pkg::ST_RANGE;
              end
            end
            cgac_pkg::CMD_TRIM: begin
              found_d = 1'b0;
              sr_d    = '0;
              sc_d    = '0;
              if (area_rows == '0 || area_cols == '0) begin
                fin        = 1'b1;
                res.status = cgac_pkg::ST_BLANK;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_RD: begin
        fin          = 1'b1;
        res.char_out = char_rd_q;
        res.attr_out = attr_rd_q;
      end
      S_SCAN: begin
        raddr = cell_addr(sr_q, sc_q);
        sv_d  = 1'b1;
        if (sc_q == area_cols - 7'd1) begin
          sc_d = '0;
          if (sr_q == area_rows - 7'd1) state_d = S_DRAIN;
          else sr_d = sr_q + 7'd1;
        end else begin
          sc_d = sc_q + 7'd1;
        end
      end
      S_DRAIN: state_d = S_DECIDE;
      S_DECIDE: begin
        mi_d = '0;
        mj_d = '0;
        if (!found_q) begin
          fin        = 1'b1;
          res.status = cgac_pkg::ST_BLANK;
        end else if (top_q != '0 || left_q != '0) begin
          state_d = S_MV_RD;
        end else begin
          state_d = S_TEND;
        end
      end
      S_MV_RD: begin
        raddr   = cell_addr(top_q + mi_q, left_q + mj_q);
        state_d = S_MV_WD;
      end
      S_MV_WD: begin
        mem_we  = 1'b1;
        waddr   = cell_addr(mi_q, mj_q);
        wchar   = char_rd_q;
        wattr   = attr_rd_q;
        state_d = S_MV_WS;
      end
      S_MV_WS: begin
        // vacated source cell, may be overwritten by a later copy
        mem_we  = 1'b1;
        waddr   = cell_addr(top_q + mi_q, left_q + mj_q);
        wchar   = blank_char_q;
        wattr   = blank_attr_q;
        state_d = S_MV_RD;
        if (mj_q == bw - 7'd1) begin
          mj_d = '0;
          if (mi_q == bh - 7'd1) state_d = S_TEND;
          else mi_d = mi_q + 7'd1;
        end else begin
          mj_d = mj_q + 7'd1;
        end
      end
      S_TEND: begin
        fin          = 1'b1;
        res.box_top  = top_q[5:0];
        res.box_left = left_q[5:0];
        res.box_rows = bh;
        res.box_cols = bw;
        if (shrink_q) begin
          shrunk_d   = 1'b1;
          act_rows_d = bh;
          act_cols_d = bw;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // result goes straight to the output register when it is free
    if (fin) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_d       = res;
        state_d     = S_IDLE;
      end else begin
        res_d   = res;
        state_d = S_DONE;
      end
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cgac_pkg::REG_GRID_ROWS: begin
          grid_rows_d = cfg_data_i[6:0];
          shrunk_d    = 1'b0;
        end
        cgac_pkg::REG_GRID_COLS: begin
          grid_cols_d = cfg_data_i[6:0];
          shrunk_d    = 1'b0;
        end
        cgac_pkg::REG_BLANK_CHAR: blank_char_d = cfg_data_i;
        cgac_pkg::REG_BLANK_ATTR: blank_attr_d = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      char_mem[waddr] <= wchar;
      attr_mem[waddr] <= wattr;
    end
    char_rd_q <= char_mem[raddr];
    attr_rd_q <= attr_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q  <= cgac_pkg::GRID_ROWS_RST;
      grid_cols_q  <= cgac_pkg::GRID_COLS_RST;
      blank_char_q <= cgac_pkg::BLANK_CHAR_RST;
      blank_attr_q <= cgac_pkg::BLANK_ATTR_RST;
      shrunk_q     <= 1'b0;
      act_rows_q   <= '0;
      act_cols_q   <= '0;
      state_q      <= S_IDLE;
      sr_q         <= '0;
      sc_q         <= '0;
      sv_q         <= 1'b0;
      found_q      <= 1'b0;
      mi_q         <= '0;
      mj_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      grid_rows_q  <= grid_rows_d;
      grid_cols_q  <= grid_cols_d;
      blank_char_q <= blank_char_d;
      blank_attr_q <= blank_attr_d;
      shrunk_q     <= shrunk_d;
      act_rows_q   <= act_rows_d;
      act_cols_q   <= act_cols_d;
      state_q      <= state_d;
      sr_q         <= sr_d;
      sc_q         <= sc_d;
      sv_q         <= sv_d;
      found_q      <= found_d;
      mi_q         <= mi_d;
      mj_q         <= mj_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pr_q     <= pr_d;
    pc_q     <= pc_d;
    top_q    <= top_d;
    left_q   <= left_d;
    bot_q    <= bot_d;
    right_q  <= right_d;
    shrink_q <= shrink_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CGAC_ASSERT_IMP(a_move_in_box, (state_q == S_MV_WD), (mi_q < bh && mj_q < bw), "move index outside box")
  `CGAC_ASSERT_IMP(a_box_in_area, (state_q == S_TEND), (found_q && bot_q >= top_q && right_q >= left_q && bot_q < area_rows && right_q < area_cols), "box outside active area")
  `CGAC_ASSERT_NEXT(a_result_held, (fin && !out_free), (state_q == S_DONE), "pending result dropped")
  `CGAC_ASSERT_IMP(a_we_source, mem_we, (in_acc || state_q == S_MV_WD || state_q == S_MV_WS), "stray memory write")

endmodule

/* test/tb_char_grid_autocrop.sv */
// ----------------------------------------------------------------------------
// tb_char_grid_autocrop
// self-checking testbench: a short table of directed commands, then random
// grid setups, each filled cell by cell and mixed with reads, writes and
// trims; results are checked against a cycle-free model of the grid, or
// against the table's expected result where a table row gives one
module tb_char_grid_autocrop;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_R     = cgac_pkg::MAX_ROWS_DEF;
  localparam int GRID_C     = cgac_pkg::MAX_COLS_DEF;
  localparam int CELLS      = GRID_R * GRID_C;
  localparam int ITEM_GOAL  = 1350;
  localparam int SETTLE     = 4;
  localparam int DRAIN      = 20;
  localparam int MAX_CYCLES = 1_000_000;
  localparam int MAX_SHOWN  = 30;

  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam cgac_pkg::in_t  IN_ZERO   = '0;
  localparam cgac_pkg::out_t RES_ZERO  = '0;
  localparam cgac_pkg::out_t RES_RANGE =
    '{cgac_pkg::ST_RANGE, 8'd0, 8'd0, 6'd0, 6'd0, 7'd0, 7'd0};
  localparam cgac_pkg::out_t RES_BLANK =
    '{cgac_pkg::ST_BLANK, 8'd0, 8'd0, 6'd0, 6'd0, 7'd0, 7'd0};

  typedef enum int {FILL_BLANK, FILL_SPARSE, FILL_DENSE, FILL_SINGLE} fill_kind_e;

  typedef struct {
    bit             is_cfg;
    logic [1:0]     reg_idx;
    logic [7:0]     reg_val;
    cgac_pkg::in_t  word;
    bit             typed;
    cgac_pkg::out_t want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  cgac_pkg::in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  cgac_pkg::out_t out_data_o;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = cgac_pkg::REG_GRID_ROWS;
  logic [7:0] cfg_data_i = '0;

  // grid model
  logic [7:0] char_mem [CELLS];
  logic [7:0] attr_mem [CELLS];
  bit         m_shrunk = 1'b0;
  logic [6:0] m_act_rows = '0;
  logic [6:0] m_act_cols = '0;
  logic [6:0] m_grid_rows = cgac_pkg::GRID_ROWS_RST;
  logic [6:0] m_grid_cols = cgac_pkg::GRID_COLS_RST;
  logic [7:0] m_blank_char = cgac_pkg::BLANK_CHAR_RST;
  logic [7:0] m_blank_attr = cgac_pkg::BLANK_ATTR_RST;

  cgac_pkg::out_t awaited_q [$];

  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int n_err = 0;
  int n_results = 0;
  int n_write = 0;
  int n_read = 0;
  int n_trim = 0;
  int n_unused = 0;
  int n_setups = 0;
  int unsigned n_cycles = 0;

  char_grid_autocrop dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int area_rows();
    int r;
    r = m_shrunk ? int'(m_act_rows) : int'(m_grid_rows);
    return (r > GRID_R) ? GRID_R : r;
  endfunction

  function automatic int area_cols();
    int c;
    c = m_shrunk ? int'(m_act_cols) : int'(m_grid_cols);
    return (c > GRID_C) ? GRID_C : c;
  endfunction

  function automatic cgac_pkg::in_t cmd_word(logic [1:0] cmd, logic [5:0] row,
                                             logic [5:0] col, logic [7:0] ch,
                                             logic [7:0] at, bit shr);
    cgac_pkg::in_t w;
    w.cmd     = cmd;
    w.row     = row;
    w.col     = col;
    w.char_in = ch;
    w.attr_in = at;
    w.shrink  = shr;
    return w;
  endfunction

  // apply one command to the model grid and return what the block should answer
  function automatic cgac_pkg::out_t apply_grid_cmd(input cgac_pkg::in_t word);
    cgac_pkg::out_t res;
    int   h, wd, i, j, top_r, left_c, bot_r, right_c, bh, bw, src, dst, at_cell;
    bit   found;
    res = '0;
    h = area_rows();
    wd = area_cols();
    found = 1'b0;
    top_r = 0;
    left_c = 0;
    bot_r = 0;
    right_c = 0;
    at_cell = int'(word.row) * GRID_C + int'(word.col);
    case (word.cmd)
      cgac_pkg::CMD_WRITE, cgac_pkg::CMD_READ: begin
        if (int'(word.row) >= h || int'(word.col) >= wd) begin
          res.status = cgac_pkg::ST_RANGE;
        end else if (word.cmd == cgac_pkg::CMD_WRITE) begin
          char_mem[at_cell] = word.char_in;
          attr_mem[at_cell] = word.attr_in;
        end else begin
          res.char_out = char_mem[at_cell];
          res.attr_out = attr_mem[at_cell];
        end
      end
      cgac_pkg::CMD_TRIM: begin
        for (i = 0; i < h; i++) begin
          for (j = 0; j < wd; j++) begin
            if (char_mem[i * GRID_C + j] != m_blank_char) begin
              if (!found) begin
                top_r = i;
                left_c = j;
                bot_r = i;
                right_c = j;
                found = 1'b1;
              end else begin
                if (j < left_c) left_c = j;
                if (i > bot_r) bot_r = i;
                if (j > right_c) right_c = j;
              end
            end
          end
        end
        if (!found) begin
          res.status = cgac_pkg::ST_BLANK;
        end else begin
          bh = bot_r - top_r + 1;
          bw = right_c - left_c + 1;
          // row-major move; a later copy may land on an already blanked source
          if (top_r != 0 || left_c != 0) begin
            for (i = 0; i < bh; i++) begin
              for (j = 0; j < bw; j++) begin
                dst = i * GRID_C + j;
                src = (top_r + i) * GRID_C + left_c + j;
                char_mem[dst] = char_mem[src];
                char_mem[src] = m_blank_char;
                attr_mem[dst] = attr_mem[src];
                attr_mem[src] = m_blank_attr;
              end
            end
          end
          if (word.shrink) begin
            m_shrunk = 1'b1;
            m_act_rows = 7'(bh);
            m_act_cols = 7'(bw);
          end
          res.box_top  = 6'(top_r);
          res.box_left = 6'(left_c);
          res.box_rows = 7'(bh);
          res.box_cols = 7'(bw);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic plan_row_t plan_cfg(logic [1:0] idx, logic [7:0] val);
    plan_row_t p;
    p.is_cfg  = 1'b1;
    p.reg_idx = idx;
    p.reg_val = val;
    p.word    = IN_ZERO;
    p.typed   = 1'b0;
    p.want    = RES_ZERO;
    return p;
  endfunction

  function automatic plan_row_t plan_cmd(cgac_pkg::in_t w);
    plan_row_t p;
    p = plan_cfg(cgac_pkg::REG_GRID_ROWS, 8'd0);
    p.is_cfg = 1'b0;
    p.word   = w;
    return p;
  endfunction

  function automatic plan_row_t plan_chk(cgac_pkg::in_t w, cgac_pkg::out_t want);
    plan_row_t p;
    p = plan_cmd(w);
    p.typed = 1'b1;
    p.want  = want;
    return p;
  endfunction

  plan_row_t plan [30] = '{
    // empty area
    plan_cfg(cgac_pkg::REG_GRID_ROWS, 8'd0),
    plan_chk(cmd_word(cgac_pkg::CMD_TRIM, 6'd0, 6'd0, 8'd0, 8'd0, 1'b0), RES_BLANK),
    plan_chk(cmd_word(cgac_pkg::CMD_READ, 6'd0, 6'd0, 8'd0, 8'd0, 1'b0), RES_RANGE),
    plan_chk(cmd_word(cgac_pkg::CMD_WRITE, 6'd0, 6'd0, 8'h5A, 8'h3C, 1'b0), RES_RANGE),
    // oversized row count saturates, single column
    plan_cfg(cgac_pkg::REG_GRID_ROWS, 8'hFF),
    plan_cfg(cgac_pkg::REG_GRID_COLS, 8'd1),
    plan_chk(cmd_word(cgac_pkg::CMD_WRITE, 6'd63, 6'd0, 8'hFF, 8'hFF, 1'b0), RES_ZERO),
    plan_chk(cmd_word(cgac_pkg::CMD_WRITE, 6'd0, 6'd1, 8'hFF, 8'hFF, 1'b1), RES_RANGE),
    plan_chk(cmd_word(cgac_pkg::CMD_READ, 6'd63, 6'd0, 8'd0, 8'd0, 1'b0),
             cgac_pkg::out_t'{cgac_pkg::ST_OK, 8'hFF, 8'hFF, 6'd0, 6'd0, 7'd0, 7'd0}),
    // 2x3 area with one mark in the far corner
    plan_cfg(cgac_pkg::REG_GRID_ROWS, 8'd2),
    plan_cfg(cgac_pkg::REG_GRID_COLS, 8'd3),
    plan_cfg(cgac_pkg::REG_BLANK_CHAR, 8'd0),
    plan_cfg(cgac_pkg::REG_BLANK_ATTR, 8'hA5),
    plan_cmd(cmd_word(cgac_pkg::CMD_WRITE, 6'd0, 6'd0, 8'd0, 8'h01, 1'b0)),
    plan_cmd(cmd_word(cgac_pkg::CMD_WRITE, 6'd0, 6'd1, 8'd0, 8'h02, 1'b0)),
    plan_cmd(cmd_word(cgac_pkg::CMD_WRITE, 6'd0, 6'd2, 8'd0, 8'h03, 1'b0)),
    plan_cmd(cmd_word(cgac_pkg::CMD_WRITE, 6'd1, 6'd0, 8'd0, 8'h04, 1'b0)),
    plan_cmd(cmd_word(cgac_pkg::CMD_WRITE, 6'd1, 6'd1, 8'd0, 8'h05, 1'b0)),
    plan_cmd(cmd_word(cgac_pkg::CMD_WRITE, 6'd1, 6'd2, 8'h41, 8'h11, 1'b0)),
    plan_chk(cmd_word(cgac_pkg::CMD_TRIM, 6'd0, 6'd0, 8'd0, 8'd0, 1'b0),
             cgac_pkg::out_t'{cgac_pkg::ST_OK, 8'd0, 8'd0, 6'd1, 6'd2, 7'd1, 7'd1}),
    plan_cmd(cmd_word(cgac_pkg::CMD_READ, 6'd0, 6'd0, 8'd0, 8'd0, 1'b0)),
    plan_cmd(cmd_word(cgac_pkg::CMD_READ, 6'd1, 6'd2, 8'd0, 8'd0, 1'b0)),
    // shrink to the box, then a grid write restores the full area
    plan_cmd(cmd_word(cgac_pkg::CMD_TRIM, 6'd0, 6'd0, 8'd0, 8'd0, 1'b1)),
    plan_chk(cmd_word(cgac_pkg::CMD_READ, 6'd0, 6'd1, 8'd0, 8'd0, 1'b0), RES_RANGE),
    plan_cmd(cmd_word(cgac_pkg::CMD_TRIM, 6'd0, 6'd0, 8'd0, 8'd0, 1'b1)),
    plan_cfg(cgac_pkg::REG_GRID_COLS, 8'd3),
    plan_cmd(cmd_word(cgac_pkg::CMD_READ, 6'd1, 6'd2, 8'd0, 8'd0, 1'b0)),
    plan_chk(cmd_word(CMD_NONE, 6'd7, 6'd9, 8'h12, 8'h34, 1'b1), RES_ZERO),
    plan_cmd(cmd_word(cgac_pkg::CMD_WRITE, 6'd0, 6'd0, 8'd0, 8'h77, 1'b0)),
    plan_chk(cmd_word(cgac_pkg::CMD_TRIM, 6'd0, 6'd0, 8'd0, 8'd0, 1'b0), RES_BLANK)
  };

  function automatic int wait_draw(bit calm);
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [7:0] mark_char();
    logic [7:0] c;
    c = 8'($urandom);
    return (c == m_blank_char) ? ~c : c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_err++;
    if (n_err <= MAX_SHOWN)
      $display("[%0t] result %0d: %s is %0d, expected %0d", $time, n_results, what, got, want);
  endtask

  task automatic check_result(input cgac_pkg::out_t got, input cgac_pkg::out_t want);
    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    if (got.char_out !== want.char_out) report_mismatch("char_out", got.char_out, want.char_out);
    if (got.attr_out !== want.attr_out) report_mismatch("attr_out", got.attr_out, want.attr_out);
    if (got.box_top !== want.box_top) report_mismatch("box_top", got.box_top, want.box_top);
    if (got.box_left !== want.box_left) report_mismatch("box_left", got.box_left, want.box_left);
    if (got.box_rows !== want.box_rows) report_mismatch("box_rows", got.box_rows, want.box_rows);
    if (got.box_cols !== want.box_cols) report_mismatch("box_cols", got.box_cols, want.box_cols);
  endtask

  // one input transfer; valid stays high when the next command follows at once
  task automatic send_item(input cgac_pkg::in_t word, input bit typed,
                           input cgac_pkg::out_t want);
    int             gap;
    cgac_pkg::out_t model_res;
    gap = wait_draw(in_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= word;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    model_res = apply_grid_cmd(word);
    awaited_q.push_back(typed ? want : model_res);
    case (word.cmd)
      cgac_pkg::CMD_WRITE: n_write++;
      cgac_pkg::CMD_READ:  n_read++;
      cgac_pkg::CMD_TRIM:  n_trim++;
      default:             n_unused++;
    endcase
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      cgac_pkg::REG_GRID_ROWS: begin
        m_grid_rows = val[6:0];
        m_shrunk = 1'b0;
      end
      cgac_pkg::REG_GRID_COLS: begin
        m_grid_cols = val[6:0];
        m_shrunk = 1'b0;
      end
      cgac_pkg::REG_BLANK_CHAR: m_blank_char = val;
      cgac_pkg::REG_BLANK_ATTR: m_blank_attr = val;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // new grid setup, full fill of the area, then a random mix of commands
  task automatic run_setup();
    logic [7:0] rv, cv, bc;
    fill_kind_e kind;
    int h, wd, i, j, pr, pc, pick, n_mix;
    logic [7:0] ch;
    cgac_pkg::in_t w;
    wait_idle();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        rv = 8'($urandom_range(1, 8));
        cv = 8'($urandom_range(1, 8));
      end
      5: begin
        rv = {1'($urandom_range(0, 1)), 7'($urandom_range(64, 127))};
        cv = 8'd1;
      end
      6: begin
        rv = 8'($urandom_range(1, 3));
        cv = {1'($urandom_range(0, 1)), 7'($urandom_range(64, 127))};
      end
      7: begin
        rv = 8'($urandom_range(9, 16));
        cv = 8'($urandom_range(9, 16));
      end
      8: begin
        // bit 7 is dropped, so both forms give an empty area
        rv = {1'($urandom_range(0, 1)), 7'd0};
        cv = 8'($urandom_range(1, 8));
        if ($urandom_range(0, 1) == 1) begin
          cv = rv;
          rv = 8'($urandom_range(1, 8));
        end
      end
      default: begin
        rv = 8'($urandom_range(1, 4));
        cv = 8'($urandom_range(17, 40));
      end
    endcase
    case ($urandom_range(0, 4))
      0: bc = cgac_pkg::BLANK_CHAR_RST;
      1: bc = 8'h00;
      2: bc = 8'hFF;
      default: bc = 8'($urandom);
    endcase
    cfg_write(cgac_pkg::REG_GRID_ROWS, rv);
    cfg_write(cgac_pkg::REG_GRID_COLS, cv);
    cfg_write(cgac_pkg::REG_BLANK_CHAR, bc);
    cfg_write(cgac_pkg::REG_BLANK_ATTR, 8'($urandom));
    in_calm  = ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
    n_setups++;

    case ($urandom_range(0, 7))
      0:       kind = FILL_BLANK;
      1, 2, 3: kind = FILL_SPARSE;
      4, 5:    kind = FILL_DENSE;
      default: kind = FILL_SINGLE;
    endcase
    h = area_rows();
    wd = area_cols();
    pr = 0;
    pc = 0;
    if (h > 0 && wd > 0) begin
      if ($urandom_range(0, 1) == 1) begin
        pr = h - 1;
        pc = wd - 1;
      end else begin
        pr = $urandom_range(0, h - 1);
        pc = $urandom_range(0, wd - 1);
      end
    end
    // every cell of the area gets written before any read or trim
    for (i = 0; i < h; i++) begin
      for (j = 0; j < wd; j++) begin
        case (kind)
          FILL_SPARSE: ch = ($urandom_range(0, 7) == 0) ? mark_char() : m_blank_char;
          FILL_DENSE:  ch = ($urandom_range(0, 3) != 0) ? mark_char() : m_blank_char;
          FILL_SINGLE: ch = (i == pr && j == pc) ? mark_char() : m_blank_char;
          default:     ch = m_blank_char;
        endcase
        send_item(cmd_word(cgac_pkg::CMD_WRITE, 6'(i), 6'(j), ch, 8'($urandom), 1'b0),
                  1'b0, RES_ZERO);
      end
    end

    n_mix = $urandom_range(8, 40);
    repeat (n_mix) begin
      h = area_rows();
      wd = area_cols();
      pick = $urandom_range(0, 19);
      w = cmd_word(cgac_pkg::CMD_WRITE, 6'($urandom), 6'($urandom), 8'($urandom),
                   8'($urandom), 1'($urandom_range(0, 1)));
      if (h > 0 && wd > 0 && pick < 14) begin
        w.row = 6'($urandom_range(0, h - 1));
        w.col = 6'($urandom_range(0, wd - 1));
      end
      if (pick < 6) begin
        if ($urandom_range(0, 1) == 1) w.char_in = m_blank_char;
      end else if (pick < 12) begin
        w.cmd = cgac_pkg::CMD_READ;
      end else if (pick < 15) begin
        w.cmd = cgac_pkg::CMD_TRIM;
      end else if (pick < 19) begin
        w.cmd = ($urandom_range(0, 1) == 1) ? cgac_pkg::CMD_READ : cgac_pkg::CMD_WRITE;
      end else begin
        w.cmd = CMD_NONE;
      end
      send_item(w, 1'b0, RES_ZERO);
    end
  endtask

  // result side: random stalls, ready held high across back-to-back transfers
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = wait_draw(out_calm);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (awaited_q.size() == 0) report_mismatch("transfer with nothing awaited", 1, 0);
      else check_result(out_data_o, awaited_q.pop_front());
      n_results++;
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still awaited", n_cycles,
               awaited_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int base;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        wait_idle();
        cfg_write(plan[k].reg_idx, plan[k].reg_val);
      end else begin
        send_item(plan[k].word, plan[k].typed, plan[k].want);
      end
    end

    base = n_write + n_read + n_trim;
    while (n_write + n_read + n_trim - base < ITEM_GOAL) run_setup();

    wait_idle();
    repeat (DRAIN) @(posedge clk_i);
    if (awaited_q.size() != 0) report_mismatch("results never delivered", 0,
                                               awaited_q.size());
    $display("covered %0d writes, %0d reads, %0d trims, %0d unused commands, %0d grid setups",
             n_write, n_read, n_trim, n_unused, n_setups);
    $display("compared %0d results, %0d field mismatches", n_results, n_err);
    if (n_err == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
